@@ rtl/skfb_pkg.sv @@
// Shared constants for the scalar Kalman filter bank.
// Holds the channel count, register indexes, reset values and beat layout.
// No dependencies.
package skfb_pkg;

  // Number of filter channels kept in the state stores.
  localparam int CHANNELS = 7;
  // Highest channel number that uses the step noise pair.
  localparam int STEP_LAST_CHAN = 3;

  // Field widths.
  localparam int CHAN_W = 3;
  localparam int DATA_W = 32;
  localparam int NOISE_W = 31;
  localparam int BEAT_W = 40;

  // Gain divider: quotient bits produced one per cycle.
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [2:0] REG_Q_STEP  = 3'd0;
  localparam logic [2:0] REG_R_STEP  = 3'd1;
  localparam logic [2:0] REG_Q_ANGLE = 3'd2;
  localparam logic [2:0] REG_R_ANGLE = 3'd3;
  localparam logic [2:0] REG_A_COEF  = 3'd4;
  localparam logic [2:0] REG_C_COEF  = 3'd5;

  // Reset values, Q16.16.
  localparam logic [NOISE_W-1:0] Q_STEP_RST  = 31'd655;
  localparam logic [NOISE_W-1:0] R_STEP_RST  = 31'd655360;
  localparam logic [NOISE_W-1:0] Q_ANGLE_RST = 31'd6554;
  localparam logic [NOISE_W-1:0] R_ANGLE_RST = 31'd6554;
  localparam logic signed [DATA_W-1:0] COEF_RST = 32'sd65536;
  localparam logic signed [DATA_W-1:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] EST_RST  = 32'sd0;
  localparam logic signed [DATA_W-1:0] COV_RST  = 32'sd65536;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

endpackage

@@ rtl/scalar_kalman_filter_bank_top.sv @@
// Top level of the scalar Kalman filter bank: sequencer, shared multiplier,
// serial gain divider, per-channel state and output register.
// Depends on skfb_pkg.
//
// An input beat on s_* carries a channel number and a Q16.16 measurement.
// The block runs one Kalman step for that channel and returns one beat on
// m_* with the channel number and the new, saturated estimate. Channel 7
// changes no state, goes straight to the final state and returns an
// estimate of zero. Noise variances and the A and C coefficients are
// written through the cfg_* port; the user must write them only while the
// block is idle, as the block itself does not enforce this.
// The restoring gain divider makes one quotient bit a cycle; the sequencer
// feeds the five products through the one shared 32x32 multiplier.
// Throughput: one item at a time; s_tready is high only in the idle state,
// so a new beat is accepted only after the previous step has finished.
// Stalls: the next item is accepted while a result still waits in the
// output register; if m_tready stays low, that step holds in its last cycle.
// Reset: rst is synchronous and active high. It restores the register
// reset values, sets every estimate to 0 and every covariance to 1.0, and
// drops m_tvalid.
module scalar_kalman_filter_bank_top
  import skfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration write port.
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BEAT_W-1:0] s_tdata,   // [2:0] chan, [34:3] measurement, [39:35] zero
  // Output stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BEAT_W-1:0] m_tdata    // [2:0] chan_out, [34:3] estimate, [39:35] zero
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_XP_M, ST_XP_R, ST_CX_M, ST_CX_R, ST_DIV, ST_K,
    ST_KI_M, ST_KI_R, ST_KC_M, ST_KC_R, ST_PN_M, ST_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic [NOISE_W-1:0]        q_step, r_step, q_angle, r_angle;
  logic signed [DATA_W-1:0]  a_coef, c_coef;

  // Per-channel state.
  logic signed [DATA_W-1:0]  est_store [CHANNELS];
  logic signed [DATA_W-1:0]  cov_store [CHANNELS];

  // Working registers of one step.
  logic [CHAN_W-1:0]         ch;
  logic                      bad_chan;
  logic signed [DATA_W-1:0]  z, pp, xp, innov, k, xn;
  logic [NOISE_W-1:0]        r_cur;

  // Shared multiplier with registered operands and product.
  logic signed [DATA_W-1:0]   mul_a, mul_b;
  logic signed [2*DATA_W-1:0] prod;

  // Gain divider.
  logic [DATA_W-1:0]         rem;
  logic [DIV_STEPS-1:0]      nq;
  logic [DATA_W-1:0]         dmag;
  logic                      den_zero, q_neg;
  logic [DIV_CNT_W-1:0]      div_cnt;

  // Saturate a 49-bit signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat49(input logic signed [48:0] v);
    if ((&v[48:31]) || !(|v[48:31])) begin
      sat49 = v[31:0];
    end else begin
      sat49 = v[48] ? SAT_MIN : SAT_MAX;
    end
  endfunction

  // Product scaled by 2^-16 with floor rounding, then saturated.
  logic signed [DATA_W-1:0]  prod_q;
  logic signed [47:0]        prod_sh;
  assign prod_sh = prod[63:16];
  assign prod_q  = sat49({prod_sh[47], prod_sh});

  // Predicted covariance from the stored covariance and the noise of the channel.
  logic [NOISE_W-1:0]        q_sel, r_sel;
  logic signed [DATA_W-1:0]  cov_sel;
  logic signed [DATA_W-1:0]  pp_calc;
  always_comb begin
    if (32'(ch) <= STEP_LAST_CHAN) begin
      q_sel = q_step;
      r_sel = r_step;
    end else begin
      q_sel = q_angle;
      r_sel = r_angle;
    end
    cov_sel = cov_store[ch];
    pp_calc = sat49({{17{cov_sel[31]}}, cov_sel} + {18'd0, q_sel});
  end

  // Divider setup: denominator pp + R and numerator magnitude |pp| * 2^16.
  logic signed [33:0]        den_sum, den_abs;
  logic [32:0]               pp_abs;
  always_comb begin
    den_sum = {{2{pp[31]}}, pp} + {3'd0, r_cur};
    den_abs = den_sum[33] ? -den_sum : den_sum;
    pp_abs  = pp[31] ? -{pp[31], pp} : {pp[31], pp};
  end

  // One restoring division step.
  logic [32:0]               trial, diff;
  logic                      q_bit;
  always_comb begin
    trial = {rem, nq[DIV_STEPS-1]};
    diff  = trial - {1'b0, dmag};
    q_bit = trial >= {1'b0, dmag};
  end

  // Signed, saturated gain from the quotient magnitude.
  logic signed [DATA_W-1:0]  k_calc;
  always_comb begin
    if (den_zero) begin
      k_calc = '0;
    end else if (q_neg) begin
      if ((|nq[47:32]) || (nq[31] && (|nq[30:0]))) begin
        k_calc = SAT_MIN;
      end else begin
        k_calc = -$signed(nq[31:0]);
      end
    end else begin
      k_calc = (|nq[47:31]) ? SAT_MAX : $signed(nq[31:0]);
    end
  end

  // Remaining sums, each saturated.
  logic signed [DATA_W-1:0]  innov_calc, xn_calc, omk_calc;
  always_comb begin
    innov_calc = sat49({{17{z[31]}}, z} - {{17{prod_q[31]}}, prod_q});
    xn_calc    = sat49({{17{xp[31]}}, xp} + {prod_sh[47], prod_sh});
    omk_calc   = sat49({{17{ONE_Q16[31]}}, ONE_Q16} - {{17{prod_q[31]}}, prod_q});
  end

  assign s_tready = (state == ST_IDLE);

  // Sequencer, datapath registers, state stores and output register.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      q_step   <= Q_STEP_RST;
      r_step   <= R_STEP_RST;
      q_angle  <= Q_ANGLE_RST;
      r_angle  <= R_ANGLE_RST;
      a_coef   <= COEF_RST;
      c_coef   <= COEF_RST;
      div_cnt  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        est_store[i] <= EST_RST;
        cov_store[i] <= COV_RST;
      end
    end else begin
      // Configuration writes.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_Q_STEP:  q_step  <= cfg_data[NOISE_W-1:0];
          REG_R_STEP:  r_step  <= cfg_data[NOISE_W-1:0];
          REG_Q_ANGLE: q_angle <= cfg_data[NOISE_W-1:0];
          REG_R_ANGLE: r_angle <= cfg_data[NOISE_W-1:0];
          REG_A_COEF:  a_coef  <= cfg_data;
          REG_C_COEF:  c_coef  <= cfg_data;
          default: ;
        endcase
      end

      // A taken beat empties the output register unless a step refills it now.
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ch       <= s_tdata[2:0];
            z        <= s_tdata[34:3];
            bad_chan <= 32'(s_tdata[2:0]) >= CHANNELS;
            state    <= (32'(s_tdata[2:0]) >= CHANNELS) ? ST_FIN : ST_LOAD;
          end
        end
        // Predict: A * x starts on the multiplier, p' = p + Q.
        ST_LOAD: begin
          pp    <= pp_calc;
          r_cur <= r_sel;
          mul_a <= a_coef;
          mul_b <= est_store[ch];
          state <= ST_XP_M;
        end
        ST_XP_M: state <= ST_XP_R;
        // x' is ready: start C * x' and set up the gain divider.
        ST_XP_R: begin
          xp       <= prod_q;
          mul_a    <= c_coef;
          mul_b    <= prod_q;
          den_zero <= (den_sum == '0);
          q_neg    <= pp[31] ^ den_sum[33];
          dmag     <= den_abs[31:0];
          rem      <= '0;
          nq       <= {pp_abs[31:0], 16'd0};
          div_cnt  <= '0;
          state    <= ST_CX_M;
        end
        ST_CX_M: state <= ST_CX_R;
        ST_CX_R: begin
          innov <= innov_calc;
          state <= ST_DIV;
        end
        // One quotient bit a cycle.
        ST_DIV: begin
          rem     <= q_bit ? diff[31:0] : trial[31:0];
          nq      <= {nq[DIV_STEPS-2:0], q_bit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_K;
          end
        end
        // Gain is ready: start k * innovation.
        ST_K: begin
          k     <= k_calc;
          mul_a <= k_calc;
          mul_b <= innov;
          state <= ST_KI_M;
        end
        ST_KI_M: state <= ST_KI_R;
        // Corrected estimate, then k * C.
        ST_KI_R: begin
          xn    <= xn_calc;
          mul_a <= k;
          mul_b <= c_coef;
          state <= ST_KC_M;
        end
        ST_KC_M: state <= ST_KC_R;
        // (1 - k*C) * p'.
        ST_KC_R: begin
          mul_a <= omk_calc;
          mul_b <= pp;
          state <= ST_PN_M;
        end
        ST_PN_M: state <= ST_FIN;
        // Store the new state and load the output register once it is free.
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, (bad_chan ? EST_RST : xn), ch};
            if (!bad_chan) begin
              est_store[ch] <= xn;
              cov_store[ch] <= prod_q;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
